FILE: hdl/dfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_pkg
// shared types and constants of the delimited field extractor
// ----------------------------------------------------------------------------
package dfe_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // register indexes of the configuration port
    localparam logic [7:0] REG_START_CHAR = 8'd0;
    localparam logic [7:0] REG_END_CHAR   = 8'd1;
    localparam logic [7:0] REG_COPY_LIMIT = 8'd2;
    localparam logic [7:0] REG_SCAN_LIMIT = 8'd3;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FOUND = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        logic [7:0]  copy_limit;
        logic [15:0] scan_limit;
    } dfe_cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  value;
        logic [15:0] position;
    } dfe_result_t;

endpackage

FILE: hdl/dfe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_cfg_regs
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module dfe_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output dfe_pkg::dfe_cfg_t cfg
);
    import dfe_pkg::*;

    dfe_cfg_t cfg_reg;
    dfe_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_CHAR: cfg_next.start_char = cfg_data[7:0];
                REG_END_CHAR:   cfg_next.end_char   = cfg_data[7:0];
                REG_COPY_LIMIT: cfg_next.copy_limit = cfg_data[7:0];
                REG_SCAN_LIMIT: cfg_next.scan_limit = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char <= 8'd0;
            cfg_reg.end_char   <= 8'd0;
            cfg_reg.copy_limit <= 8'd0;
            cfg_reg.scan_limit <= 16'hFFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/dfe_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_scan
// scan state and the per-byte step: search, copy, slide, done
// ----------------------------------------------------------------------------
module dfe_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           ch,
    input  logic                 first,
    input  dfe_pkg::dfe_cfg_t    cfg,
    output dfe_pkg::dfe_result_t result
);
    import dfe_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_COPY   = 2'd1,
        PH_SLIDE  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] budget_reg, budget_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] offset_reg, offset_next;

    phase_t      ph;
    phase_t      ph_start;
    logic [15:0] bud;
    logic [15:0] bud_et;
    logic [7:0]  cnt;
    logic [7:0]  cnt_inc;
    logic [15:0] off;
    logic        run_end_test;

    always_comb begin
        ph  = first ? PH_SEARCH : phase_reg;
        bud = first ? cfg.scan_limit : budget_reg;
        cnt = first ? 8'd0 : count_reg;
        off = first ? 16'd0 : offset_reg;

        ph_start     = (cfg.copy_limit != 8'd0) ? PH_COPY : PH_SLIDE;
        phase_next   = ph;
        budget_next  = bud;
        count_next   = cnt;
        offset_next  = off + 16'd1;
        result       = '0;
        result.kind  = KIND_BYTE;
        run_end_test = 1'b0;
        bud_et       = bud;
        cnt_inc      = cnt + 8'd1;

        unique case (ph)
            PH_SEARCH: begin
                if (bud == 16'd0) begin
                    phase_next   = PH_DONE;
                    result.valid = 1'b1;
                    result.kind  = KIND_NONE;
                end else begin
                    budget_next = bud - 16'd1;
                    count_next  = 8'd0;
                    cnt_inc     = 8'd1;
                    if (cfg.start_char == 8'd0 && ch > SPACE_CHAR) begin
                        // byte above space opens the field and is examined again
                        phase_next   = ph_start;
                        bud_et       = bud - 16'd1;
                        run_end_test = 1'b1;
                    end else if (ch == cfg.start_char) begin
                        phase_next = ph_start;
                    end
                end
            end
            PH_COPY, PH_SLIDE: begin
                run_end_test = 1'b1;
            end
            default: begin
            end
        endcase

        if (run_end_test) begin
            if (ch == cfg.end_char) begin
                phase_next      = PH_DONE;
                result.valid    = 1'b1;
                result.kind     = KIND_FOUND;
                result.position = off;
            end else if (ch < SPACE_CHAR || bud_et == 16'd0) begin
                phase_next   = PH_DONE;
                result.valid = 1'b1;
                result.kind  = KIND_NONE;
            end else begin
                budget_next = bud_et - 16'd1;
                if (phase_next == PH_COPY) begin
                    count_next = cnt_inc;
                    if (cnt_inc >= cfg.copy_limit) begin
                        phase_next = PH_SLIDE;
                    end else begin
                        result.valid = 1'b1;
                        result.kind  = KIND_BYTE;
                        result.value = ch;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DONE;
            budget_reg <= 16'd0;
            count_reg  <= 8'd0;
            offset_reg <= 16'd0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            budget_reg <= budget_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

endmodule

FILE: hdl/delimited_field_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_extractor_top
// extracts one delimited field from a byte stream and reports the terminator
// ----------------------------------------------------------------------------
// The block takes one text word per cycle while s_ready is high and produces
// at most one result word per input word. A word marked with s_first restarts
// the scan: the block looks for start_char (or, with start_char 0, the first
// byte above space, which is copied), then passes on up to copy_limit-1 field
// bytes as kind 0 words, slides to end_char and reports its offset as a kind 1
// word, or reports not-found as a kind 2 word when a control byte or the scan
// budget ends the search. Bytes outside a text cause no result. Throughput is
// one word per cycle while the result side takes words. The accepted word sits
// in the input register; when it steps on, the combinational scan step loads
// its result into the result register, which drives m_*. A stalled result
// register holds the input register, and s_ready drops once both are full.
// Configuration writes are taken every cycle and must happen only while the
// block is idle.
// ----------------------------------------------------------------------------
module delimited_field_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input text words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_first,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_value,
    output logic [15:0] m_position
);
    import dfe_pkg::*;

    dfe_cfg_t    cfg;
    dfe_result_t result;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_first_reg;

    // result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_value_reg;
    logic [15:0] out_position_reg;

    logic step_en;

    // the held word moves on when the result register is free or being drained
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    // new word enters while the held one steps, so the stream never bubbles
    assign s_ready = !in_valid_reg || step_en;

    dfe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfe_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .ch      (in_ch_reg),
        .first   (in_first_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input register: control reset, payload without reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg    <= s_ch;
            in_first_reg <= s_first;
        end
    end

    // result register: loaded on a step, cleared when taken with nothing new
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && result.valid) begin
            out_kind_reg     <= result.kind;
            out_value_reg    <= result.value;
            out_position_reg <= result.position;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_value    = out_value_reg;
    assign m_position = out_position_reg;

endmodule

FILE: hdl/dfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
module dfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_value,
    input logic [15:0] m_position
);
    import dfe_pkg::*;

    // only the three defined result kinds appear
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_BYTE || m_kind == KIND_FOUND || m_kind == KIND_NONE))
        else $error("illegal result kind");

    // value carries data only for copied bytes
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_BYTE) |-> (m_value == 8'd0))
        else $error("value set on non-byte result");

    // position carries data only for a found terminator
    a_position_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_FOUND) |-> (m_position == 16'd0))
        else $error("position set on non-found result");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_value)
                                   && $stable(m_position)))
        else $error("result changed while stalled");

endmodule

bind delimited_field_extractor_top dfe_checker u_dfe_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_value    (m_value),
    .m_position (m_position)
);

FILE: verif/delimited_field_extractor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_extractor_top_tb
// self-checking bench for the delimited field extractor
// ----------------------------------------------------------------------------
// Words go in on s_* and results come out on m_*. Both sides idle and stall at
// random. Each accepted input word runs through a scan model held in a small
// scoreboard class, and that model queues the result word it predicts. Every
// result word is matched field by field against the oldest queued prediction.
// The bench starts with directed texts for marker, terminator, budget and
// copy-limit corners. After that, many random register settings each get a
// run of mostly well-formed texts, with noise mixed in.
// ----------------------------------------------------------------------------
module delimited_field_extractor_top_tb;
    import dfe_pkg::*;

    // scan phases of the model
    typedef enum logic [1:0] {
        SCAN_SEARCH = 2'd0,
        SCAN_COPY   = 2'd1,
        SCAN_SLIDE  = 2'd2,
        SCAN_DONE   = 2'd3
    } scan_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [15:0] position;
    } field_word_t;

    // scan model plus the queue of result words it still expects
    class field_scoreboard;
        dfe_cfg_t      cfg;
        scan_phase_t   phase;
        logic [15:0]   budget;
        logic [7:0]    copied;
        logic [15:0]   offset;
        field_word_t   result_words_due[$];
        int unsigned   n_words, n_bytes, n_found, n_none, errors;

        function new();
            cfg.start_char = 8'h00;
            cfg.end_char   = 8'h00;
            cfg.copy_limit = 8'h00;
            cfg.scan_limit = 16'hFFFF;
            phase  = SCAN_DONE;
            budget = '0;
            copied = '0;
            offset = '0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            case (idx)
                REG_START_CHAR: cfg.start_char = data[7:0];
                REG_END_CHAR:   cfg.end_char   = data[7:0];
                REG_COPY_LIMIT: cfg.copy_limit = data[7:0];
                REG_SCAN_LIMIT: cfg.scan_limit = data;
                default: ;
            endcase
        endfunction

        function void expect_word(kind_t kind, logic [7:0] value, logic [15:0] position);
            field_word_t w;
            w.kind     = kind;
            w.value    = value;
            w.position = position;
            result_words_due.push_back(w);
        endfunction

        function void note_text_word(logic [7:0] ch, logic first);
            logic [15:0] pos;
            n_words++;
            if (first) begin
                phase  = SCAN_SEARCH;
                budget = cfg.scan_limit;
                copied = '0;
                offset = '0;
            end
            pos    = offset;
            offset = offset + 16'd1;
            if (phase == SCAN_DONE)
                return;
            if (phase == SCAN_SEARCH) begin
                if (budget == 16'd0) begin
                    phase = SCAN_DONE;
                    expect_word(KIND_NONE, 8'h00, 16'h0000);
                    return;
                end
                budget = budget - 16'd1;
                copied = '0;
                if (cfg.start_char == 8'h00 && ch > SPACE_CHAR) begin
                    // this byte opens the field and is examined again below
                    phase = (cfg.copy_limit != 8'h00) ? SCAN_COPY : SCAN_SLIDE;
                end else if (ch == cfg.start_char) begin
                    phase = (cfg.copy_limit != 8'h00) ? SCAN_COPY : SCAN_SLIDE;
                    return;
                end else begin
                    return;
                end
            end
            // terminator wins over control byte and budget
            if (ch == cfg.end_char) begin
                phase = SCAN_DONE;
                expect_word(KIND_FOUND, 8'h00, pos);
                return;
            end
            if (ch < SPACE_CHAR || budget == 16'd0) begin
                phase = SCAN_DONE;
                expect_word(KIND_NONE, 8'h00, 16'h0000);
                return;
            end
            budget = budget - 16'd1;
            if (phase == SCAN_COPY) begin
                copied = copied + 8'd1;
                if (copied >= cfg.copy_limit)
                    phase = SCAN_SLIDE;
                else
                    expect_word(KIND_BYTE, ch, 16'h0000);
            end
        endfunction

        function void check_result_word(logic [1:0] kind, logic [7:0] value,
                                        logic [15:0] position);
            field_word_t w;
            if (result_words_due.size() == 0) begin
                $error("unexpected result word: kind %0d value 0x%02h position %0d",
                       kind, value, position);
                errors++;
                return;
            end
            w = result_words_due.pop_front();
            if (kind !== w.kind) begin
                $error("kind: expected %0d, actual %0d", w.kind, kind);
                errors++;
            end
            if (value !== w.value) begin
                $error("value: expected 0x%02h, actual 0x%02h", w.value, value);
                errors++;
            end
            if (position !== w.position) begin
                $error("position: expected %0d, actual %0d", w.position, position);
                errors++;
            end
            case (w.kind)
                KIND_BYTE:  n_bytes++;
                KIND_FOUND: n_found++;
                default:    n_none++;
            endcase
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_ch;
    logic        s_first;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_value;
    logic [15:0] m_position;

    field_scoreboard sb = new();

    // when set, neither side idles
    bit          calm;
    int unsigned sink_stall;
    int unsigned n_settings;
    int unsigned random_words;
    int unsigned phase_words;
    logic [7:0]  text_q[$];

    delimited_field_extractor_top DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .s_first    (s_first),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_value    (m_value),
        .m_position (m_position)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit, well above the slowest legal run
    initial begin
        #1500000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: draw a stall per word, then hold ready until a word moves
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            sink_stall = calm ? 0 : $urandom_range(0, 10);
            if (sink_stall != 0) begin
                m_ready <= 1'b0;
                repeat (sink_stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // result monitor, samples at the edge where the word moves
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result_word(m_kind, m_value, m_position);
    end

    // one text word; valid is only dropped when a gap follows
    task automatic send_word(input logic [7:0] ch, input logic first);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= ch;
        s_first <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_text_word(ch, first);
    endtask

    // the sender goes idle so the last word is not offered again
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.result_words_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // registers change only once the block has gone quiet
    task automatic set_config(input logic [7:0] start_c, input logic [7:0] end_c,
                              input logic [7:0] copy_n, input logic [15:0] scan_n);
        wait_drained();
        // a word that yields nothing may still be in the pipe
        repeat (6) @(posedge aclk);
        write_reg(REG_START_CHAR, {8'h00, start_c});
        write_reg(REG_END_CHAR, {8'h00, end_c});
        write_reg(REG_COPY_LIMIT, {8'h00, copy_n});
        write_reg(REG_SCAN_LIMIT, scan_n);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // printable byte that differs from ex
    function automatic logic [7:0] pick_printable(input logic [7:0] ex);
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        if (c == ex)
            c = (c == 8'h7E) ? 8'h21 : c + 8'd1;
        return c;
    endfunction

    // random text: mostly preamble, marker, field, terminator, tail
    task automatic send_text();
        int unsigned shape;
        int          n;
        int          i;
        logic [7:0]  c;
        text_q.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            // pure noise
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                if (sb.cfg.start_char == 8'h00)
                    c = 8'($urandom_range(1, 32));
                else
                    c = pick_printable(sb.cfg.start_char);
                text_q.push_back(c);
            end
            if (sb.cfg.start_char != 8'h00)
                text_q.push_back(sb.cfg.start_char);
            else if ($urandom_range(0, 3) == 0)
                text_q.push_back(8'h00);
            else
                text_q.push_back(pick_printable(sb.cfg.end_char));
            n = $urandom_range(0, (sb.cfg.copy_limit > 10) ? 12 : sb.cfg.copy_limit + 2);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0)
                    c = 8'($urandom_range(8'h80, 8'hFF));
                else
                    c = pick_printable(sb.cfg.end_char);
                text_q.push_back(c);
            end
            text_q.push_back(sb.cfg.end_char);
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                text_q.push_back(8'($urandom_range(0, 255)));
            // broken text: one byte replaced by anything
            if (shape == 1)
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        // shape 2 carries no first flag and mostly lands in the ignored state
        for (i = 0; i < text_q.size(); i++)
            send_word(text_q[i], (shape != 2) && (i == 0));
        random_words += text_q.size();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_ch      = '0;
        s_first   = 1'b0;
        calm      = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte before any text start is ignored
        send_word("q", 1'b0);

        // marker and terminator, copy limit drops the fourth field byte
        set_config("[", "]", 8'd4, 16'hFFFF);
        send_word("a", 1'b1);
        send_word("[", 1'b0);
        send_word("x", 1'b0);
        send_word("y", 1'b0);
        send_word("z", 1'b0);
        send_word("w", 1'b0);
        send_word("k", 1'b0);
        send_word("]", 1'b0);
        send_word("z", 1'b0);

        // start 0: first byte above space opens and is copied, control terminator
        set_config(8'h00, 8'h0A, 8'd255, 16'd5);
        send_word(" ", 1'b1);
        send_word("H", 1'b0);
        send_word("i", 1'b0);
        send_word(8'h0A, 1'b0);
        // nul opens the field, budget runs out while copying
        send_word(8'h00, 1'b1);
        send_word("a", 1'b0);
        send_word("b", 1'b0);
        send_word("c", 1'b0);
        send_word("d", 1'b0);
        send_word("e", 1'b0);
        // control byte in the field ends the scan
        send_word("Z", 1'b1);
        send_word(8'h09, 1'b0);

        // zero budget gives up at once in the search
        set_config(8'hFF, 8'hFF, 8'd0, 16'd0);
        send_word("x", 1'b1);

        // copy limit lowered while copying, then budget ends the slide
        set_config(8'hFF, 8'h00, 8'd255, 16'd3);
        send_word(8'hFF, 1'b1);
        send_word("A", 1'b0);
        set_config(8'hFF, 8'h00, 8'd1, 16'd3);
        send_word("B", 1'b0);
        send_word("C", 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);

        // random settings, each with a run of texts
        random_words = 0;
        while (random_words < 1500) begin
            set_config(
                ($urandom_range(0, 2) == 0) ? 8'h00 :
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                  8'($urandom_range(8'h21, 8'h7E)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8'h1F)) :
                    ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                                  8'($urandom_range(8'h21, 8'h7E)),
                ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1)) :
                    ($urandom_range(0, 6) == 0) ? 8'd255 : 8'($urandom_range(2, 10)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12)) :
                    ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(13, 60)));
            calm = ($urandom_range(0, 5) == 0);
            phase_words = random_words;
            while (random_words - phase_words < 50) begin
                // sender holds off until every pending result is out
                if ($urandom_range(0, 14) == 0)
                    wait_drained();
                send_text();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d text words over %0d register settings",
                 sb.n_words, n_settings);
        $display("checked %0d field bytes, %0d terminators found, %0d not-found reports",
                 sb.n_bytes, sb.n_found, sb.n_none);
        if (sb.errors == 0 && sb.result_words_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
